FILE: rtl/core/mcal_pkg.sv
// ----------------------------------------------------------------------------
// mcal_pkg
// Shared constants and types for the calendar time pipeline: reciprocal
// multipliers for the constant divisions and the month end table.
// ----------------------------------------------------------------------------
package mcal_pkg;

    // divisors after the power-of-two part has been shifted out
    localparam logic [6:0]  DIV_MS   = 7'd125;   // 1000  = 8 * 125
    localparam logic [9:0]  DIV_DAY  = 10'd675;  // 86400 = 128 * 675
    localparam logic [7:0]  DIV_HOUR = 8'd225;   // 3600  = 16 * 225
    localparam logic [3:0]  DIV_MIN  = 4'd15;    // 60    = 4 * 15

    // floor(2^k / divisor); estimate is exact or one low
    localparam logic [31:0] MUL_MS   = 32'd2199023255;  // k = 38
    localparam logic [22:0] MUL_DAY  = 23'd6362914;     // k = 32
    localparam logic [16:0] MUL_HOUR = 17'd74565;       // k = 24
    localparam logic [12:0] MUL_MIN  = 13'd4369;        // k = 16

    localparam logic [9:0]  US_PER_MS = 10'd1000;

    localparam logic [3:0]  NUM_MONTHS     = 4'd12;
    localparam logic [3:0]  MONTH_PAST_DEC = 4'd13;

    // last day of year for each month, common year
    localparam logic [8:0] MONTH_END [12] = '{
        9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic       in_year;
    } month_info_t;

    // month end with the leap day added from february on
    function automatic logic [8:0] month_end(input logic [3:0] idx, input logic leap);
        logic [8:0] e;
        e = '0;
        if (idx < NUM_MONTHS)
        begin
            e = MONTH_END[idx];
            if (leap && (idx != 4'd0))
            begin
                e = e + 9'd1;
            end
        end
        return e;
    endfunction

endpackage

FILE: rtl/core/mcal_month_decode.sv
// ----------------------------------------------------------------------------
// mcal_month_decode
// Maps a day of year to month and day of month by comparing it against
// all month ends in parallel.
// ----------------------------------------------------------------------------
module mcal_month_decode (
    input  logic [8:0]           doy,
    input  logic                 leap,
    output mcal_pkg::month_info_t info
);
    import mcal_pkg::*;

    logic [3:0] past;
    logic [8:0] start;
    logic [8:0] diff;

    // count of month ends that lie before the day
    always_comb
    begin
        past = '0;
        for (int i = 0; i < 12; i++)
        begin
            past = past + {3'b000, (doy > month_end(4'(i), leap))};
        end
    end

    // day of month relative to the end of the previous month
    always_comb
    begin
        start = '0;
        if (past != 4'd0)
        begin
            start = month_end(past - 4'd1, leap);
        end
        diff = doy - start;
    end

    always_comb
    begin
        info.month        = past + 4'd1;
        info.in_year      = (past < NUM_MONTHS);
        info.day_of_month = info.in_year ? diff[4:0] : 5'd0;
    end

endmodule

FILE: rtl/core/msec_of_year_to_calendar_time.sv
// ----------------------------------------------------------------------------
// msec_of_year_to_calendar_time
// Splits a millisecond count within a year into day of year, month, day of
// month and time of day, with a microsecond field below the second.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low and holds each
// result in an output register until it is taken. Four divisions by
// constants (1000, 86400, 3600, 60) are each done as a reciprocal multiply
// in one stage and a single compare-and-subtract correction in the next.
// Every stage holds its own valid bit, so a stall at the output fills empty
// stages first and input is taken as long as the first stage can move.
// February has 29 days whenever the year is divisible by 4; a day past
// December gives month 13 with valid_res low.
// ----------------------------------------------------------------------------
module msec_of_year_to_calendar_time (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] year_value,
    input  logic [34:0] msec_in_year,
    input  logic [9:0]  micro_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [19:0] microsecond,
    output logic        valid_res
);
    import mcal_pkg::*;

    localparam int STAGES = 8;

    logic [STAGES:1] v_reg;
    logic [STAGES+1:1] adv;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        adv[STAGES+1] = !out_stall;
        for (int k = STAGES; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = v_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: reciprocal multiply for seconds
    logic [31:0] s1_x_reg;
    logic [2:0]  s1_lo_reg;
    logic        s1_leap_reg;
    logic [9:0]  s1_uoff_reg;
    logic [25:0] s1_qe_reg;
    logic [63:0] s1_prod_next;

    assign s1_prod_next = 64'(msec_in_year[34:3]) * 64'(MUL_MS);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_x_reg    <= msec_in_year[34:3];
            s1_lo_reg   <= msec_in_year[2:0];
            s1_leap_reg <= (year_value[1:0] == 2'b00);
            s1_uoff_reg <= micro_offset;
            s1_qe_reg   <= s1_prod_next[63:38];
        end
    end

    // stage 2: correct seconds, form millisecond remainder
    logic [25:0] s2_secs_reg;
    logic [9:0]  s2_ms_reg;
    logic        s2_leap_reg;
    logic [9:0]  s2_uoff_reg;
    logic [32:0] s2_rem_wide;
    logic [7:0]  s2_rem;
    logic [25:0] s2_secs_next;
    logic [6:0]  s2_r_next;

    always_comb
    begin
        s2_rem_wide = 33'(s1_x_reg) - (33'(s1_qe_reg) * 33'(DIV_MS));
        s2_rem      = s2_rem_wide[7:0];
        if (s2_rem >= 8'(DIV_MS))
        begin
            s2_secs_next = s1_qe_reg + 26'd1;
            s2_r_next    = 7'(s2_rem - 8'(DIV_MS));
        end
        else
        begin
            s2_secs_next = s1_qe_reg;
            s2_r_next    = s2_rem[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_secs_reg <= s2_secs_next;
            s2_ms_reg   <= {s2_r_next, s1_lo_reg};
            s2_leap_reg <= s1_leap_reg;
            s2_uoff_reg <= s1_uoff_reg;
        end
    end

    // stage 3: reciprocal multiply for days, microsecond field
    logic [25:0] s3_secs_reg;
    logic        s3_leap_reg;
    logic [19:0] s3_us_reg;
    logic [8:0]  s3_qe_reg;
    logic [41:0] s3_prod_next;

    assign s3_prod_next = 42'(s2_secs_reg[25:7]) * 42'(MUL_DAY);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_secs_reg <= s2_secs_reg;
            s3_leap_reg <= s2_leap_reg;
            s3_us_reg   <= 20'(s2_ms_reg) * 20'(US_PER_MS) + 20'(s2_uoff_reg);
            s3_qe_reg   <= s3_prod_next[40:32];
        end
    end

    // stage 4: correct day of year, seconds within the day
    logic [8:0]  s4_doy_reg;
    logic [16:0] s4_rem_reg;
    logic        s4_leap_reg;
    logic [19:0] s4_us_reg;
    logic [18:0] s4_rem_wide;
    logic [10:0] s4_rem;
    logic [8:0]  s4_doy_next;
    logic [9:0]  s4_r_next;

    always_comb
    begin
        s4_rem_wide = s3_secs_reg[25:7] - (19'(s3_qe_reg) * 19'(DIV_DAY));
        s4_rem      = s4_rem_wide[10:0];
        if (s4_rem >= 11'(DIV_DAY))
        begin
            s4_doy_next = s3_qe_reg + 9'd1;
            s4_r_next   = 10'(s4_rem - 11'(DIV_DAY));
        end
        else
        begin
            s4_doy_next = s3_qe_reg;
            s4_r_next   = s4_rem[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_doy_reg  <= s4_doy_next;
            s4_rem_reg  <= {s4_r_next, s3_secs_reg[6:0]};
            s4_leap_reg <= s3_leap_reg;
            s4_us_reg   <= s3_us_reg;
        end
    end

    // stage 5: reciprocal multiply for hours, month lookup
    logic [8:0]  s5_doy_reg;
    logic [16:0] s5_rem_reg;
    logic [4:0]  s5_qe_reg;
    logic [19:0] s5_us_reg;
    month_info_t s5_info_reg;
    month_info_t s5_info_next;
    logic [29:0] s5_prod_next;

    assign s5_prod_next = 30'(s4_rem_reg[16:4]) * 30'(MUL_HOUR);

    mcal_month_decode u_month (
        .doy  (s4_doy_reg),
        .leap (s4_leap_reg),
        .info (s5_info_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_doy_reg  <= s4_doy_reg;
            s5_rem_reg  <= s4_rem_reg;
            s5_qe_reg   <= s5_prod_next[28:24];
            s5_us_reg   <= s4_us_reg;
            s5_info_reg <= s5_info_next;
        end
    end

    // stage 6: correct hour, seconds within the hour
    logic [8:0]  s6_doy_reg;
    logic [19:0] s6_us_reg;
    month_info_t s6_info_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_hrem_reg;
    logic [12:0] s6_rem_wide;
    logic [8:0]  s6_rem;
    logic [4:0]  s6_hour_next;
    logic [7:0]  s6_r_next;

    always_comb
    begin
        s6_rem_wide = s5_rem_reg[16:4] - (13'(s5_qe_reg) * 13'(DIV_HOUR));
        s6_rem      = s6_rem_wide[8:0];
        if (s6_rem >= 9'(DIV_HOUR))
        begin
            s6_hour_next = s5_qe_reg + 5'd1;
            s6_r_next    = 8'(s6_rem - 9'(DIV_HOUR));
        end
        else
        begin
            s6_hour_next = s5_qe_reg;
            s6_r_next    = s6_rem[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_doy_reg  <= s5_doy_reg;
            s6_us_reg   <= s5_us_reg;
            s6_info_reg <= s5_info_reg;
            s6_hour_reg <= s6_hour_next;
            s6_hrem_reg <= {s6_r_next, s5_rem_reg[3:0]};
        end
    end

    // stage 7: reciprocal multiply for minutes
    logic [8:0]  s7_doy_reg;
    logic [19:0] s7_us_reg;
    month_info_t s7_info_reg;
    logic [4:0]  s7_hour_reg;
    logic [11:0] s7_hrem_reg;
    logic [5:0]  s7_qe_reg;
    logic [22:0] s7_prod_next;

    assign s7_prod_next = 23'(s6_hrem_reg[11:2]) * 23'(MUL_MIN);

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_doy_reg  <= s6_doy_reg;
            s7_us_reg   <= s6_us_reg;
            s7_info_reg <= s6_info_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_hrem_reg <= s6_hrem_reg;
            s7_qe_reg   <= s7_prod_next[21:16];
        end
    end

    // stage 8: correct minute, second, output register
    logic [9:0]  s8_rem_wide;
    logic [4:0]  s8_rem;
    logic [5:0]  s8_min_next;
    logic [3:0]  s8_r_next;
    logic [8:0]  out_doy_reg;
    logic [19:0] out_us_reg;
    month_info_t out_info_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_min_reg;
    logic [5:0]  out_sec_reg;

    always_comb
    begin
        s8_rem_wide = s7_hrem_reg[11:2] - (10'(s7_qe_reg) * 10'(DIV_MIN));
        s8_rem      = s8_rem_wide[4:0];
        if (s8_rem >= 5'(DIV_MIN))
        begin
            s8_min_next = s7_qe_reg + 6'd1;
            s8_r_next   = 4'(s8_rem - 5'(DIV_MIN));
        end
        else
        begin
            s8_min_next = s7_qe_reg;
            s8_r_next   = s8_rem[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            out_doy_reg  <= s7_doy_reg;
            out_us_reg   <= s7_us_reg;
            out_info_reg <= s7_info_reg;
            out_hour_reg <= s7_hour_reg;
            out_min_reg  <= s8_min_next;
            out_sec_reg  <= {s8_r_next, s7_hrem_reg[1:0]};
        end
    end

    assign day_of_year  = out_doy_reg;
    assign month        = out_info_reg.month;
    assign day_of_month = out_info_reg.day_of_month;
    assign hour         = out_hour_reg;
    assign minute       = out_min_reg;
    assign second       = out_sec_reg;
    assign microsecond  = out_us_reg;
    assign valid_res    = out_info_reg.in_year;

`ifndef SYNTHESIS
    // an accepted item always lands in the first stage
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[1])
        else $error("accepted item not captured");

    // quotient corrections keep the time of day in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
        else $error("time of day out of range");

    // a day outside the year reports month 13 and day 0
    a_past_dec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> (month == MONTH_PAST_DEC) && (day_of_month == 5'd0))
        else $error("inconsistent past december result");
`endif

endmodule

FILE: bench/calendar_checker.sv
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both channels of the calendar time block. Every accepted item is
// turned into an expected calendar date and time of day, and every accepted
// result is compared field by field with the oldest expected date.
// ----------------------------------------------------------------------------
module calendar_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [11:0] year_value,
    input  logic [34:0] msec_in_year,
    input  logic [9:0]  micro_offset,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [8:0]  day_of_year,
    input  logic [3:0]  month,
    input  logic [4:0]  day_of_month,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic [19:0] microsecond,
    input  logic        valid_res,
    output int unsigned fail_count,
    output int unsigned dates_pending,
    output int unsigned dates_checked
);

    localparam longint unsigned MSEC_PER_SEC = 1000;
    localparam longint unsigned SEC_PER_DAY  = 86400;
    localparam int unsigned     SEC_PER_HOUR = 3600;
    localparam int unsigned     SEC_PER_MIN  = 60;
    localparam int unsigned     USEC_PER_MS  = 1000;
    localparam int unsigned     LAST_MONTH   = 12;

    typedef struct packed {
        logic [8:0]  day_of_year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] microsecond;
        logic        valid_res;
    } calendar_t;

    calendar_t expected_dates [$];
    calendar_t seen_date;
    calendar_t want_date;

    initial
    begin
        fail_count    = 0;
        dates_pending = 0;
        dates_checked = 0;
    end

    // length of month idx (0 = january), february grows in years divisible by 4
    function automatic int unsigned month_length(input int unsigned idx, input bit leap);
        int unsigned len;
        case (idx)
            1:       len = leap ? 29 : 28;
            3, 5, 8, 10: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    // expected calendar date and time of day for one input item
    function automatic calendar_t calendar_of(input logic [11:0] yr,
                                              input logic [34:0] ms_count,
                                              input logic [9:0]  us_off);
        calendar_t       res;
        longint unsigned count;
        longint unsigned secs;
        longint unsigned days;
        int unsigned     tod;
        int unsigned     left;
        int unsigned     mon;
        int unsigned     usec;
        bit              leap;
        bit              found;
        count = 64'(ms_count);
        secs  = count / MSEC_PER_SEC;
        days  = secs / SEC_PER_DAY;
        tod   = int'(secs % SEC_PER_DAY);
        usec  = int'(count % MSEC_PER_SEC) * USEC_PER_MS + 32'(us_off);
        leap  = (yr[1:0] == 2'b00);

        // walk the month lengths; a day equal to the month length stays in it
        left  = int'(days);
        mon   = 1;
        found = 1'b0;
        for (int i = 0; i < LAST_MONTH; i++)
        begin
            if (!found)
            begin
                if (left <= month_length(i, leap))
                begin
                    found = 1'b1;
                end
                else
                begin
                    left = left - month_length(i, leap);
                    mon  = mon + 1;
                end
            end
        end

        res.day_of_year  = days[8:0];
        res.month        = mon[3:0];
        res.valid_res    = (mon <= LAST_MONTH);
        res.day_of_month = res.valid_res ? left[4:0] : 5'd0;
        res.hour         = 5'(tod / SEC_PER_HOUR);
        res.minute       = 6'((tod % SEC_PER_HOUR) / SEC_PER_MIN);
        res.second       = 6'(tod % SEC_PER_MIN);
        res.microsecond  = usec[19:0];
        return res;
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic compare_date(input calendar_t got, input calendar_t want);
        if (got.day_of_year !== want.day_of_year)
            report($sformatf("day_of_year %0d, expected %0d", got.day_of_year, want.day_of_year));
        if (got.month !== want.month)
            report($sformatf("month %0d, expected %0d", got.month, want.month));
        if (got.day_of_month !== want.day_of_month)
            report($sformatf("day_of_month %0d, expected %0d",
                             got.day_of_month, want.day_of_month));
        if (got.hour !== want.hour)
            report($sformatf("hour %0d, expected %0d", got.hour, want.hour));
        if (got.minute !== want.minute)
            report($sformatf("minute %0d, expected %0d", got.minute, want.minute));
        if (got.second !== want.second)
            report($sformatf("second %0d, expected %0d", got.second, want.second));
        if (got.microsecond !== want.microsecond)
            report($sformatf("microsecond %0d, expected %0d",
                             got.microsecond, want.microsecond));
        if (got.valid_res !== want.valid_res)
            report($sformatf("valid_res %0d, expected %0d", got.valid_res, want.valid_res));
    endtask

    // predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_dates.push_back(calendar_of(year_value, msec_in_year, micro_offset));
            end
            if (out_valid && !out_stall)
            begin
                seen_date = '{day_of_year, month, day_of_month, hour, minute, second,
                              microsecond, valid_res};
                dates_checked++;
                if (expected_dates.size() == 0)
                begin
                    report($sformatf("result with nothing expected, day_of_year %0d",
                                     day_of_year));
                end
                else
                begin
                    want_date = expected_dates.pop_front();
                    compare_date(seen_date, want_date);
                end
            end
            dates_pending <= expected_dates.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the calendar time block with directed month, leap year and range
// corner items followed by random timestamps, with random gaps on the input
// and random stalls on the output. A checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RANDOM_ITEMS = 650;
    localparam int          CYCLE_LIMIT  = 800000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          LAST_TOD_MS  = 86399999;
    localparam longint      MSEC_PER_DAY = 86400000;
    localparam logic [11:0] LEAP_YEAR    = 12'd1972;
    localparam logic [11:0] COMMON_YEAR  = 12'd1901;

    // day of year on which each month ends in a common year, led by 0 for january
    localparam int MONTH_START [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                        334, 365};

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [11:0] year_value   = '0;
    logic [34:0] msec_in_year = '0;
    logic [9:0]  micro_offset = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] microsecond;
    logic        valid_res;

    int unsigned fail_count;
    int unsigned dates_pending;
    int unsigned dates_checked;
    int unsigned items_sent   = 0;
    int unsigned items_wild   = 0;
    int          cycle_count  = 0;

    msec_of_year_to_calendar_time i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .year_value   (year_value),
        .msec_in_year (msec_in_year),
        .micro_offset (micro_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .day_of_year  (day_of_year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .microsecond  (microsecond),
        .valid_res    (valid_res)
    );

    calendar_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .year_value    (year_value),
        .msec_in_year  (msec_in_year),
        .micro_offset  (micro_offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .day_of_year   (day_of_year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .microsecond   (microsecond),
        .valid_res     (valid_res),
        .fail_count    (fail_count),
        .dates_pending (dates_pending),
        .dates_checked (dates_checked)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 dates_pending);
        $display("CHECK FAILED");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // output stall pattern, with long stretches of no stall now and then
    initial
    begin
        int free_len;
        int hold_len;
        @(posedge clk);
        forever
        begin
            out_stall <= 1'b0;
            free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 6);
            repeat (free_len) @(posedge clk);
            hold_len = idle_len();
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
            end
        end
    end

    function automatic logic [34:0] at_day(input int doy, input int tod_ms);
        longint count;
        count = longint'(doy) * MSEC_PER_DAY + tod_ms;
        return count[34:0];
    endfunction

    // present one item and hold it until taken; called at a rising edge
    task automatic send_item(input logic [11:0] yr, input logic [34:0] ms_count,
                             input logic [9:0] us_off, input bit no_gap);
        int gap;
        in_valid     <= 1'b1;
        year_value   <= yr;
        msec_in_year <= ms_count;
        micro_offset <= us_off;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        gap = no_gap ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the input until every expected result has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (dates_pending != 0);
    endtask

    // stimulus and verdict
    initial
    begin
        int          r;
        int          doy;
        int          tod;
        logic [2:0]  count_hi;
        logic [31:0] count_lo;
        logic [11:0] yr;
        logic [34:0] ms_count;
        logic [9:0]  us_off;
        bit          wild;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // day zero and the first days of the year
        send_item(LEAP_YEAR, at_day(0, 0), 10'd0, 1'b0);
        send_item(COMMON_YEAR, at_day(0, LAST_TOD_MS), 10'd999, 1'b0);
        send_item(COMMON_YEAR, at_day(1, 0), 10'd0, 1'b1);
        // january end and february start
        send_item(COMMON_YEAR, at_day(31, 1), 10'd1, 1'b1);
        send_item(COMMON_YEAR, at_day(32, 0), 10'd0, 1'b0);
        // end of february, common and leap
        send_item(COMMON_YEAR, at_day(59, 43200000), 10'd500, 1'b1);
        send_item(COMMON_YEAR, at_day(60, 0), 10'd0, 1'b1);
        send_item(LEAP_YEAR, at_day(60, LAST_TOD_MS), 10'd999, 1'b1);
        send_item(LEAP_YEAR, at_day(61, 0), 10'd0, 1'b0);
        send_item(12'd2100, at_day(60, 0), 10'd0, 1'b0);
        // end of december and one day past it
        send_item(COMMON_YEAR, at_day(365, LAST_TOD_MS), 10'd999, 1'b1);
        send_item(COMMON_YEAR, at_day(366, 0), 10'd0, 1'b1);
        send_item(LEAP_YEAR, 35'd31708799999, 10'd999, 1'b1);
        send_item(LEAP_YEAR, at_day(367, 0), 10'd0, 1'b0);
        // counts and offsets beyond the stated ranges, any year value
        send_item(12'hFFF, 35'h7FFFFFFFF, 10'h3FF, 1'b1);
        send_item(12'd0, at_day(200, 45296789), 10'd1000, 1'b0);
        send_item(12'hAAA, 35'h2AAAAAAAA, 10'h155, 1'b1);
        send_item(12'h555, 35'h555555555, 10'h2AA, 1'b0);
        // mid-year times
        send_item(12'd1976, at_day(335, 3723004), 10'd7, 1'b0);
        send_item(12'd2099, at_day(180, 45296789), 10'd500, 1'b0);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                drain();
            end
            r    = $urandom_range(0, 99);
            wild = (r < 10);
            if (wild)
            begin
                count_hi = 3'($urandom_range(0, 7));
                count_lo = $urandom;
                yr       = 12'($urandom_range(0, 4095));
                ms_count = {count_hi, count_lo};
                us_off   = 10'($urandom_range(0, 1023));
                items_wild++;
            end
            else
            begin
                if (r < 40)
                begin
                    // around a month boundary
                    doy = MONTH_START[$urandom_range(0, 12)] + $urandom_range(0, 3) - 1;
                    if (doy < 0)
                        doy = 0;
                end
                else
                begin
                    doy = $urandom_range(0, 366);
                end
                case ($urandom_range(0, 7))
                    0:       tod = 0;
                    1:       tod = LAST_TOD_MS;
                    default: tod = $urandom_range(0, LAST_TOD_MS);
                endcase
                yr       = 12'($urandom_range(1901, 2099));
                ms_count = at_day(doy, tod);
                us_off   = 10'($urandom_range(0, 999));
            end
            // every fourth block of fifty goes back to back
            send_item(yr, ms_count, us_off, ((n / 50) % 4) == 3);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items (%0d with fields outside the usual ranges), checked %0d results",
                 items_sent, items_wild, dates_checked);
        $display("covered month and leap-day boundaries, days past december and random stalls");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mcal_pkg.sv
rtl/core/mcal_month_decode.sv
rtl/core/msec_of_year_to_calendar_time.sv
bench/calendar_checker.sv
bench/tb_top.sv
